FILE: src/assert_macros.svh
// Assertion macros used by the top-level RTL file of the coordinate map.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define CHK_ALWAYS(lbl, expr) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) \
    else $error("invariant violated");
`define CHK_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("implication violated");
`else
`define CHK_ALWAYS(lbl, expr)
`define CHK_IMPLY(lbl, ante, cons)
`endif
`endif

FILE: src/hacm_pkg.sv
// Package of the hexahedron coordinate map: widths, codes and stage layout.
`default_nettype none
package hacm_pkg;
  localparam int COORD_BITS    = 21;
  localparam int FRACTION_BITS = 10;
  localparam int CFG_BITS      = 63;

  localparam int EW    = COORD_BITS + 1;        // edge vector component
  localparam int RW    = COORD_BITS + 4;        // right-hand side component
  localparam int PW    = 2 * EW;                // edge product / cross component
  localparam int SW    = PW + 4;                // forward sum
  localparam int LOW   = EW;                    // low split of a cross component
  localparam int PLW   = RW + LOW + 1;
  localparam int PHW   = RW + PW - LOW;
  localparam int DETW  = RW + PW + 3;           // determinant
  localparam int SH    = FRACTION_BITS + 1;     // numerator scale, one extra half bit
  localparam int QBITS = COORD_BITS + 1;        // quotient bits before rounding
  localparam int WIDE  = DETW + QBITS + 2;      // division remainder

  localparam int ONE     = 2 ** FRACTION_BITS;
  localparam int SAT_MAX = 2 ** (COORD_BITS - 1) - 1;
  localparam int SAT_MIN = -(2 ** (COORD_BITS - 1));

  // stage layout: six front stages, prep, QBITS+1 divide steps, output
  localparam int PREP_STAGE = 6;
  localparam int NUM_STAGES = PREP_STAGE + QBITS + 3;

  typedef enum logic {
    OP_TO_PHYS = 1'b0,
    OP_TO_REF  = 1'b1
  } op_e;

  localparam logic [1:0] REG_ORIGIN = 2'd0;
  localparam logic [1:0] REG_ALONG_X = 2'd1;
  localparam logic [1:0] REG_ALONG_Y = 2'd2;
  localparam logic [1:0] REG_ALONG_Z = 2'd3;

  typedef struct packed {
    op_e                    op;
    logic                   degen;
    logic                   fwd_ovf;
    logic [COORD_BITS-1:0]  fwd_x;
    logic [COORD_BITS-1:0]  fwd_y;
    logic [COORD_BITS-1:0]  fwd_z;
  } side_t;
endpackage
`default_nettype wire

FILE: src/hexahedron_affine_coordinate_map_top.sv
// Top level of the hexahedron affine coordinate map pipeline.
`default_nettype none
`include "assert_macros.svh"
// Maps points between the reference cube [-1,1]^3 and a parallelepiped hexahedron
// set by four corner registers (origin and its three axis neighbors, signed Q10.10
// packed x/y/z in bits 20:0, 41:21, 62:42). operation 0 maps reference to
// physical; operation 1 inverts by Cramer's rule and a restoring divider with one
// quotient bit per stage. One word enters every cycle unless a stall holds the
// input; the result word leaves after the 23 divider steps, which follow the
// product and determinant stages. Bubbles close up under stall, so the input
// keeps taking words while a result waits, until all stages fill. Write the corner
// registers only while the pipeline is empty; they are read at the first stage.
module hexahedron_affine_coordinate_map_top (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                cfg_valid_i,
  output logic                                     cfg_ready_o,
  input  wire logic [1:0]                          cfg_index_i,
  input  wire logic [hacm_pkg::CFG_BITS-1:0]       cfg_data_i,
  input  wire logic                                in_valid_i,
  output logic                                     in_stall_o,
  input  wire logic                                operation_i,
  input  wire logic signed [hacm_pkg::COORD_BITS-1:0] coord_x_i,
  input  wire logic signed [hacm_pkg::COORD_BITS-1:0] coord_y_i,
  input  wire logic signed [hacm_pkg::COORD_BITS-1:0] coord_z_i,
  output logic                                     out_valid_o,
  input  wire logic                                out_stall_i,
  output logic signed [hacm_pkg::COORD_BITS-1:0]   mapped_x_o,
  output logic signed [hacm_pkg::COORD_BITS-1:0]   mapped_y_o,
  output logic signed [hacm_pkg::COORD_BITS-1:0]   mapped_z_o,
  output logic                                     degenerate_o,
  output logic                                     overflow_o
);
  localparam int CB = hacm_pkg::COORD_BITS;
  localparam int NS = hacm_pkg::NUM_STAGES;
  localparam int PS = hacm_pkg::PREP_STAGE;
  localparam int QB = hacm_pkg::QBITS;

  // configuration registers
  logic [hacm_pkg::CFG_BITS-1:0] corner_q [4];

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int j = 0; j < 4; j++) corner_q[j] <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        hacm_pkg::REG_ORIGIN:  corner_q[0] <= cfg_data_i;
        hacm_pkg::REG_ALONG_X: corner_q[1] <= cfg_data_i;
        hacm_pkg::REG_ALONG_Y: corner_q[2] <= cfg_data_i;
        hacm_pkg::REG_ALONG_Z: corner_q[3] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // valid bits and stage enables: a stage loads when empty or when it drains
  logic v_q [NS];
  logic en [NS];

  for (genvar s = 0; s < NS; s++) begin : g_en
    if (s == NS - 1) begin : g_last
      assign en[s] = !v_q[s] || !out_stall_i;
    end else begin : g_mid
      assign en[s] = !v_q[s] || en[s+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < NS; s++) v_q[s] <= 1'b0;
    end else begin
      if (en[0]) v_q[0] <= in_valid_i;
      for (int s = 1; s < NS; s++) begin
        if (en[s]) v_q[s] <= v_q[s-1];
      end
    end
  end

  assign in_stall_o = !en[0];

  // stage 1: capture point, origin and edge vectors
  hacm_pkg::op_e            op1_q;
  logic signed [CB-1:0]     p1_q [3];
  logic signed [CB-1:0]     g1_q [3];
  logic signed [hacm_pkg::EW-1:0] e1_q [3][3];

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      op1_q <= hacm_pkg::op_e'(operation_i);
      p1_q[0] <= coord_x_i;
      p1_q[1] <= coord_y_i;
      p1_q[2] <= coord_z_i;
      for (int k = 0; k < 3; k++) begin
        g1_q[k] <= $signed(corner_q[0][k*CB +: CB]);
        for (int j = 0; j < 3; j++) begin
          e1_q[j][k] <= hacm_pkg::EW'($signed(corner_q[j+1][k*CB +: CB]))
                      - hacm_pkg::EW'($signed(corner_q[0][k*CB +: CB]));
        end
      end
    end
  end

  // stage 2: forward products, cross-product terms, right-hand side
  hacm_pkg::op_e            op2_q;
  logic signed [CB-1:0]     g2_q [3];
  logic signed [hacm_pkg::PW-1:0] fp2_q [3][3];
  logic signed [hacm_pkg::PW-1:0] cpa2_q [3][3];
  logic signed [hacm_pkg::PW-1:0] cpb2_q [3][3];
  logic signed [hacm_pkg::RW-1:0] r2_q [3];
  logic signed [hacm_pkg::EW-1:0] ea2_q [3];

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      op2_q <= op1_q;
      for (int k = 0; k < 3; k++) begin
        int k1;
        int k2;
        int ja;
        int jb;
        k1 = (k == 2) ? 0 : k + 1;
        k2 = (k == 0) ? 2 : k - 1;
        g2_q[k]  <= g1_q[k];
        ea2_q[k] <= e1_q[0][k];
        r2_q[k]  <= (hacm_pkg::RW'(p1_q[k]) <<< 1) - hacm_pkg::RW'(e1_q[0][k])
                  - hacm_pkg::RW'(e1_q[1][k]) - hacm_pkg::RW'(e1_q[2][k])
                  - (hacm_pkg::RW'(g1_q[k]) <<< 1);
        for (int j = 0; j < 3; j++) begin
          fp2_q[k][j] <= (hacm_pkg::PW'(p1_q[j]) + hacm_pkg::PW'(hacm_pkg::ONE))
                       * hacm_pkg::PW'(e1_q[j][k]);
        end
        // cross products: e2 x e3, e3 x e1, e1 x e2
        for (int m = 0; m < 3; m++) begin
          ja = (m == 2) ? 0 : m + 1;
          jb = (m == 0) ? 2 : ((m == 1) ? 0 : 1);
          cpa2_q[m][k] <= hacm_pkg::PW'(e1_q[ja][k1]) * hacm_pkg::PW'(e1_q[jb][k2]);
          cpb2_q[m][k] <= hacm_pkg::PW'(e1_q[ja][k2]) * hacm_pkg::PW'(e1_q[jb][k1]);
        end
      end
    end
  end

  // stage 3: forward sums, cross-product differences
  hacm_pkg::op_e            op3_q;
  logic signed [hacm_pkg::SW-1:0] s3_q [3];
  logic signed [hacm_pkg::PW-1:0] c3_q [3][3];
  logic signed [hacm_pkg::RW-1:0] r3_q [3];
  logic signed [hacm_pkg::EW-1:0] ea3_q [3];

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      op3_q <= op2_q;
      for (int k = 0; k < 3; k++) begin
        r3_q[k]  <= r2_q[k];
        ea3_q[k] <= ea2_q[k];
        s3_q[k]  <= (hacm_pkg::SW'(g2_q[k]) <<< hacm_pkg::SH)
                  + hacm_pkg::SW'(fp2_q[k][0]) + hacm_pkg::SW'(fp2_q[k][1])
                  + hacm_pkg::SW'(fp2_q[k][2]) + hacm_pkg::SW'(hacm_pkg::ONE);
        for (int m = 0; m < 3; m++) c3_q[m][k] <= cpa2_q[m][k] - cpb2_q[m][k];
      end
    end
  end

  // stage 4: finish the forward map, split dot-product partials
  hacm_pkg::side_t          side4_q;
  logic signed [hacm_pkg::PLW-1:0] pl4_q [4][3];
  logic signed [hacm_pkg::PHW-1:0] ph4_q [4][3];
  logic signed [hacm_pkg::SW-1:0]  fsh [3];
  logic [CB-1:0]            fval [3];
  logic                     fovf;

  always_comb begin
    fovf = 1'b0;
    for (int k = 0; k < 3; k++) begin
      fsh[k] = s3_q[k] >>> hacm_pkg::SH;
      if (fsh[k] > hacm_pkg::SW'(hacm_pkg::SAT_MAX)) begin
        fval[k] = CB'(hacm_pkg::SAT_MAX);
        fovf = 1'b1;
      end else if (fsh[k] < hacm_pkg::SW'(hacm_pkg::SAT_MIN)) begin
        fval[k] = CB'(hacm_pkg::SAT_MIN);
        fovf = 1'b1;
      end else begin
        fval[k] = fsh[k][CB-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      side4_q.op      <= op3_q;
      side4_q.degen   <= 1'b0;
      side4_q.fwd_ovf <= fovf;
      side4_q.fwd_x   <= fval[0];
      side4_q.fwd_y   <= fval[1];
      side4_q.fwd_z   <= fval[2];
      for (int k = 0; k < 3; k++) begin
        // rows for the three numerators use r; the last row is e1 for D
        for (int m = 0; m < 4; m++) begin
          logic signed [hacm_pkg::RW-1:0] u;
          logic signed [hacm_pkg::PW-1:0] c;
          u = (m == 3) ? hacm_pkg::RW'(ea3_q[k]) : r3_q[k];
          c = (m == 3) ? c3_q[0][k] : c3_q[m][k];
          pl4_q[m][k] <= hacm_pkg::PLW'(u) * $signed({1'b0, c[hacm_pkg::LOW-1:0]});
          ph4_q[m][k] <= hacm_pkg::PHW'(u)
                       * hacm_pkg::PHW'($signed(c[hacm_pkg::PW-1:hacm_pkg::LOW]));
        end
      end
    end
  end

  // stage 5: combine partials; stage 6: sum to determinants
  hacm_pkg::side_t          side5_q;
  hacm_pkg::side_t          side6_q;
  logic signed [hacm_pkg::DETW-1:0] pr5_q [4][3];
  logic signed [hacm_pkg::DETW-1:0] det6_q [4];

  always_ff @(posedge clk_i) begin
    if (en[4]) begin
      side5_q <= side4_q;
      for (int m = 0; m < 4; m++) begin
        for (int k = 0; k < 3; k++) begin
          pr5_q[m][k] <= (hacm_pkg::DETW'(ph4_q[m][k]) <<< hacm_pkg::LOW)
                       + hacm_pkg::DETW'(pl4_q[m][k]);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[5]) begin
      side6_q <= side5_q;
      for (int m = 0; m < 4; m++) det6_q[m] <= pr5_q[m][0] + pr5_q[m][1] + pr5_q[m][2];
    end
  end

  // divider pipeline: entry 0 is the prep stage, entries 1..QB+1 one bit each
  hacm_pkg::side_t          dside_q [QB+2];
  logic [hacm_pkg::WIDE-1:0] rem_q [QB+2][3];
  logic [QB-1:0]            quo_q [QB+2][3];
  logic                     neg_q [QB+2][3];
  logic                     dovf_q [QB+2][3];
  logic [hacm_pkg::DETW-1:0] den_q [QB+2];

  always_ff @(posedge clk_i) begin
    if (en[PS]) begin
      dside_q[0].op      <= side6_q.op;
      dside_q[0].degen   <= (side6_q.op == hacm_pkg::OP_TO_REF) && (det6_q[3] == '0);
      dside_q[0].fwd_ovf <= side6_q.fwd_ovf;
      dside_q[0].fwd_x   <= side6_q.fwd_x;
      dside_q[0].fwd_y   <= side6_q.fwd_y;
      dside_q[0].fwd_z   <= side6_q.fwd_z;
      den_q[0] <= det6_q[3][hacm_pkg::DETW-1] ? hacm_pkg::DETW'(-det6_q[3])
                                               : hacm_pkg::DETW'(det6_q[3]);
      for (int l = 0; l < 3; l++) begin
        logic [hacm_pkg::DETW-1:0] nmag;
        nmag = det6_q[l][hacm_pkg::DETW-1] ? hacm_pkg::DETW'(-det6_q[l])
                                            : hacm_pkg::DETW'(det6_q[l]);
        rem_q[0][l]  <= hacm_pkg::WIDE'({nmag, {hacm_pkg::SH{1'b0}}});
        quo_q[0][l]  <= '0;
        neg_q[0][l]  <= det6_q[l][hacm_pkg::DETW-1] ^ det6_q[3][hacm_pkg::DETW-1];
        dovf_q[0][l] <= 1'b0;
      end
    end
  end

  for (genvar i = 1; i <= QB + 1; i++) begin : g_div
    localparam int K = QB + 1 - i;
    always_ff @(posedge clk_i) begin
      if (en[PS+i]) begin
        dside_q[i] <= dside_q[i-1];
        den_q[i]   <= den_q[i-1];
        for (int l = 0; l < 3; l++) begin
          logic [hacm_pkg::WIDE-1:0] t;
          logic                      ge;
          t  = hacm_pkg::WIDE'(den_q[i-1]) << K;
          ge = rem_q[i-1][l] >= t;
          neg_q[i][l] <= neg_q[i-1][l];
          if (K == QB) begin
            // quotient would not fit: flag, leave remainder alone
            rem_q[i][l]  <= rem_q[i-1][l];
            quo_q[i][l]  <= quo_q[i-1][l];
            dovf_q[i][l] <= ge;
          end else begin
            rem_q[i][l]  <= ge ? rem_q[i-1][l] - t : rem_q[i-1][l];
            quo_q[i][l]  <= quo_q[i-1][l] | (ge ? (QB'(1) << K) : '0);
            dovf_q[i][l] <= dovf_q[i-1][l];
          end
        end
      end
    end
  end

  // output stage: round the half-bit quotient, saturate, select result
  logic [CB-1:0] ival [3];
  logic          iovf;
  logic [CB-1:0] res [3];
  logic          res_deg;
  logic          res_ovf;

  always_comb begin
    iovf = 1'b0;
    for (int l = 0; l < 3; l++) begin
      logic [QB-1:0] rnd;
      logic [QB-1:0] lim;
      logic [QB-1:0] mg;
      rnd = QB'((QB'(quo_q[QB+1][l]) + QB'(1)) >> 1);
      if ((&quo_q[QB+1][l])) rnd = QB'(1) << (QB - 1);
      lim = neg_q[QB+1][l] ? (QB'(1) << (CB - 1)) : QB'(hacm_pkg::SAT_MAX);
      if (dovf_q[QB+1][l] || rnd > lim) begin
        mg = lim;
        iovf = 1'b1;
      end else begin
        mg = rnd;
      end
      ival[l] = neg_q[QB+1][l] ? CB'(-mg) : CB'(mg);
    end
    if (dside_q[QB+1].op == hacm_pkg::OP_TO_PHYS) begin
      res[0] = dside_q[QB+1].fwd_x;
      res[1] = dside_q[QB+1].fwd_y;
      res[2] = dside_q[QB+1].fwd_z;
      res_deg = 1'b0;
      res_ovf = dside_q[QB+1].fwd_ovf;
    end else if (dside_q[QB+1].degen) begin
      res[0] = '0;
      res[1] = '0;
      res[2] = '0;
      res_deg = 1'b1;
      res_ovf = 1'b0;
    end else begin
      res[0] = ival[0];
      res[1] = ival[1];
      res[2] = ival[2];
      res_deg = 1'b0;
      res_ovf = iovf;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[NS-1]) begin
      mapped_x_o   <= $signed(res[0]);
      mapped_y_o   <= $signed(res[1]);
      mapped_z_o   <= $signed(res[2]);
      degenerate_o <= res_deg;
      overflow_o   <= res_ovf;
    end
  end

  assign out_valid_o = v_q[NS-1];

  // checks
  `CHK_IMPLY(a_degen_no_ovf, out_valid_o && degenerate_o, !overflow_o)
  `CHK_IMPLY(a_degen_zero, out_valid_o && degenerate_o,
             mapped_x_o == '0 && mapped_y_o == '0 && mapped_z_o == '0)
  `CHK_IMPLY(a_stall_full, in_stall_o, v_q[0] && v_q[PS] && out_valid_o && out_stall_i)
endmodule
`default_nettype wire

FILE: verif/tb.sv
// Testbench for the hexahedron affine coordinate map: queued stimulus, prediction, checks.
`timescale 1ns / 1ps
module tb;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_WAIT  = 40;  // pipeline is 31 deep

  typedef logic signed [hacm_pkg::COORD_BITS-1:0] coord_t;
  typedef logic signed [127:0]          det_t;

  typedef struct {
    hacm_pkg::op_e op;
    coord_t x, y, z;
  } point_t;

  typedef struct {
    coord_t x, y, z;
    logic   degen, ovf;
  } mapped_t;

  logic clk_i, rst_ni;
  logic cfg_valid_i, cfg_ready_o;
  logic [1:0] cfg_index_i;
  logic [hacm_pkg::CFG_BITS-1:0] cfg_data_i;
  logic in_valid_i, in_stall_o, operation_i;
  coord_t coord_x_i, coord_y_i, coord_z_i;
  logic out_valid_o, out_stall_i;
  coord_t mapped_x_o, mapped_y_o, mapped_z_o;
  logic degenerate_o, overflow_o;

  hexahedron_affine_coordinate_map_top dut (.*);

  // Shadow of the corner registers, updated on each write handshake.
  logic [hacm_pkg::CFG_BITS-1:0] corner [4];

  point_t  point_q[$];
  mapped_t mapped_q[$];
  int      errors;
  int      cycle;
  bit      sender_idle_on, receiver_idle_on;
  int      send_wait, recv_wait, hold_cnt;
  bit      hold_done;
  bit      hold_arm;

  initial begin
    clk_i = 0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic longint vtx(int r, int k);
    coord_t c;
    c = corner[r][k*hacm_pkg::COORD_BITS +: hacm_pkg::COORD_BITS];
    return longint'(c);
  endfunction

  function automatic det_t det3(longint u[3], longint v[3], longint w[3]);
    det_t a0, a1, a2, c0, c1, c2;
    a0 = u[0]; a1 = u[1]; a2 = u[2];
    c0 = v[1] * w[2] - v[2] * w[1];
    c1 = v[2] * w[0] - v[0] * w[2];
    c2 = v[0] * w[1] - v[1] * w[0];
    return a0 * c0 + a1 * c1 + a2 * c2;
  endfunction

  // Rounded quotient num * 2^F / den, ties away from zero, saturated.
  function automatic coord_t scaled_quotient(det_t num, det_t den, ref logic ovf);
    logic        neg;
    logic [127:0] n, d, q, rm, lim;
    neg = (num < 0) != (den < 0);
    n = (num < 0) ? -num : num;
    d = (den < 0) ? -den : den;
    n = n << hacm_pkg::FRACTION_BITS;
    q = n / d;
    rm = n % d;
    if ((rm << 1) >= d) q = q + 1;
    lim = neg ? (128'd1 << (hacm_pkg::COORD_BITS - 1))
              : (128'd1 << (hacm_pkg::COORD_BITS - 1)) - 1;
    if (q > lim) begin
      q = lim;
      ovf = 1'b1;
    end
    return neg ? coord_t'(-q) : coord_t'(q);
  endfunction

  function automatic coord_t clamp(longint v, ref logic ovf);
    if (v > hacm_pkg::SAT_MAX) begin
      ovf = 1'b1;
      return coord_t'(hacm_pkg::SAT_MAX);
    end
    if (v < hacm_pkg::SAT_MIN) begin
      ovf = 1'b1;
      return coord_t'(hacm_pkg::SAT_MIN);
    end
    return coord_t'(v);
  endfunction

  function automatic mapped_t map_point(point_t pt);
    longint  g0[3], e1[3], e2[3], e3[3], p[3], r[3], s;
    det_t    dd;
    mapped_t m;
    logic    ovf;
    coord_t  o[3];
    ovf = 1'b0;
    p[0] = pt.x; p[1] = pt.y; p[2] = pt.z;
    for (int k = 0; k < 3; k++) begin
      g0[k] = vtx(hacm_pkg::REG_ORIGIN, k);
      e1[k] = vtx(hacm_pkg::REG_ALONG_X, k) - g0[k];
      e2[k] = vtx(hacm_pkg::REG_ALONG_Y, k) - g0[k];
      e3[k] = vtx(hacm_pkg::REG_ALONG_Z, k) - g0[k];
    end
    m.degen = 1'b0;
    if (pt.op == hacm_pkg::OP_TO_PHYS) begin
      for (int k = 0; k < 3; k++) begin
        s = 2 * hacm_pkg::ONE * g0[k] + (hacm_pkg::ONE + p[0]) * e1[k]
          + (hacm_pkg::ONE + p[1]) * e2[k] + (hacm_pkg::ONE + p[2]) * e3[k];
        o[k] = clamp((s + hacm_pkg::ONE) >>> (hacm_pkg::FRACTION_BITS + 1), ovf);
      end
    end else begin
      for (int k = 0; k < 3; k++)
        r[k] = 2 * p[k] - e1[k] - e2[k] - e3[k] - 2 * g0[k];
      dd = det3(e1, e2, e3);
      if (dd == 0) begin
        o[0] = '0; o[1] = '0; o[2] = '0;
        m.degen = 1'b1;
      end else begin
        o[0] = scaled_quotient(det3(r, e2, e3), dd, ovf);
        o[1] = scaled_quotient(det3(e1, r, e3), dd, ovf);
        o[2] = scaled_quotient(det3(e1, e2, r), dd, ovf);
      end
    end
    m.x = o[0]; m.y = o[1]; m.z = o[2]; m.ovf = ovf;
    return m;
  endfunction

  // Sender: predict on each accepted word, then load the next after its gap.
  always @(posedge clk_i or negedge rst_ni) begin
    point_t pt;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      operation_i <= 1'b0;
      coord_x_i <= '0; coord_y_i <= '0; coord_z_i <= '0;
      send_wait <= 0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        pt.op = hacm_pkg::op_e'(operation_i);
        pt.x = coord_x_i; pt.y = coord_y_i; pt.z = coord_z_i;
        mapped_q.push_back(map_point(pt));
      end
      if (!in_valid_i || !in_stall_o) begin
        if (send_wait > 0) begin
          in_valid_i <= 1'b0;
          send_wait <= send_wait - 1;
        end else if (point_q.size() > 0) begin
          pt = point_q.pop_front();
          operation_i <= pt.op;
          coord_x_i <= pt.x; coord_y_i <= pt.y; coord_z_i <= pt.z;
          in_valid_i <= 1'b1;
          send_wait <= sender_idle_on ? $urandom_range(0, 8) : 0;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Receiver: check each accepted word against the oldest prediction,
  // then hold off for the drawn number of cycles.
  always @(posedge clk_i or negedge rst_ni) begin
    mapped_t m;
    int      w;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      recv_wait <= 0;
    end else begin
      w = recv_wait;
      if (out_valid_o && !out_stall_i) begin
        if (mapped_q.size() == 0) begin
          $display("%0t: unexpected word x=%0d y=%0d z=%0d", $time,
                   mapped_x_o, mapped_y_o, mapped_z_o);
          errors++;
        end else begin
          m = mapped_q.pop_front();
          if (m.x !== mapped_x_o || m.y !== mapped_y_o || m.z !== mapped_z_o
              || m.degen !== degenerate_o || m.ovf !== overflow_o) begin
            $display("%0t: mismatch expected x=%0d y=%0d z=%0d degen=%0b ovf=%0b",
                     $time, m.x, m.y, m.z, m.degen, m.ovf);
            $display("%0t:          actual   x=%0d y=%0d z=%0d degen=%0b ovf=%0b",
                     $time, mapped_x_o, mapped_y_o, mapped_z_o, degenerate_o,
                     overflow_o);
            errors++;
          end
        end
        w = receiver_idle_on ? $urandom_range(0, 8) : 0;
      end
      if (hold_cnt > 0) out_stall_i <= 1'b1;
      else if (w > 0) begin
        out_stall_i <= 1'b1;
        w = w - 1;
      end else out_stall_i <= 1'b0;
      recv_wait <= w;
    end
  end

  // Long hold-off: stall the output once while the sender keeps going.
  always @(posedge clk_i) begin
    if (hold_cnt > 0) hold_cnt <= hold_cnt - 1;
    else if (!hold_done && hold_arm && in_valid_i) begin
      hold_cnt <= 300;
      hold_done <= 1'b1;
    end
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycle <= cycle + 1;
    if (cycle > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  task automatic write_corner(logic [1:0] idx, logic [hacm_pkg::CFG_BITS-1:0] val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    corner[idx] = val;
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic [hacm_pkg::CFG_BITS-1:0] pack3(coord_t x, coord_t y, coord_t z);
    return {z, y, x};
  endfunction

  function automatic coord_t rand_coord(int span);
    if (span == 0) return coord_t'($urandom);
    return coord_t'($urandom_range(0, 2 * span) - span);
  endfunction

  // Box aligned to the axes, with edges of random length and sign.
  task automatic set_box(int span, int edge_max);
    coord_t ox, oy, oz;
    ox = rand_coord(span); oy = rand_coord(span); oz = rand_coord(span);
    write_corner(hacm_pkg::REG_ORIGIN, pack3(ox, oy, oz));
    write_corner(hacm_pkg::REG_ALONG_X, pack3(ox + rand_coord(edge_max), oy, oz));
    write_corner(hacm_pkg::REG_ALONG_Y, pack3(ox, oy + rand_coord(edge_max), oz));
    write_corner(hacm_pkg::REG_ALONG_Z, pack3(ox, oy, oz + rand_coord(edge_max)));
  endtask

  task automatic add_point(hacm_pkg::op_e op, coord_t x, coord_t y, coord_t z);
    point_t pt;
    pt.op = op; pt.x = x; pt.y = y; pt.z = z;
    point_q.push_back(pt);
  endtask

  task automatic add_random(int n);
    int span;
    for (int i = 0; i < n; i++) begin
      span = ($urandom_range(0, 1) == 0) ? 0 : 1500;
      add_point(hacm_pkg::op_e'($urandom_range(0, 1)), rand_coord(span),
                rand_coord(span), rand_coord(span));
    end
  endtask

  // Extremes mixed with the reference cube bounds -1 and 1, and the origin, both directions.
  task automatic add_directed();
    coord_t ext[4];
    ext[0] = coord_t'(hacm_pkg::SAT_MIN); ext[1] = coord_t'(hacm_pkg::SAT_MAX);
    ext[2] = coord_t'(-hacm_pkg::ONE);    ext[3] = coord_t'(hacm_pkg::ONE);
    for (int i = 0; i < 4; i++)
      for (int o = 0; o < 2; o++)
        add_point(hacm_pkg::op_e'(o), ext[i], ext[(i + 1) % 4], ext[(i + 2) % 4]);
    add_point(hacm_pkg::OP_TO_PHYS, '0, '0, '0);
    add_point(hacm_pkg::OP_TO_REF, '0, '0, '0);
    add_point(hacm_pkg::OP_TO_PHYS, coord_t'(-1), coord_t'(1), coord_t'(-1));
  endtask

  task automatic drain();
    while (point_q.size() != 0 || in_valid_i || mapped_q.size() != 0)
      @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
  endtask

  task automatic run_phase(int n, bit idle_tx, bit idle_rx);
    sender_idle_on = idle_tx;
    receiver_idle_on = idle_rx;
    add_random(n);
    drain();
  endtask

  initial begin
    errors = 0; cycle = 0; hold_cnt = 0; hold_done = 0; hold_arm = 0;
    sender_idle_on = 0; receiver_idle_on = 0;
    cfg_valid_i = 0; cfg_index_i = '0; cfg_data_i = '0;
    for (int i = 0; i < 4; i++) corner[i] = '0;
    rst_ni = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1;

    // Reset corners: every inverse is degenerate.
    add_directed();
    drain();

    // Unit cube scaled: identity-like map.
    write_corner(hacm_pkg::REG_ORIGIN, pack3(coord_t'(-hacm_pkg::ONE),
                 coord_t'(-hacm_pkg::ONE), coord_t'(-hacm_pkg::ONE)));
    write_corner(hacm_pkg::REG_ALONG_X, pack3(coord_t'(hacm_pkg::ONE),
                 coord_t'(-hacm_pkg::ONE), coord_t'(-hacm_pkg::ONE)));
    write_corner(hacm_pkg::REG_ALONG_Y, pack3(coord_t'(-hacm_pkg::ONE),
                 coord_t'(hacm_pkg::ONE), coord_t'(-hacm_pkg::ONE)));
    write_corner(hacm_pkg::REG_ALONG_Z, pack3(coord_t'(-hacm_pkg::ONE),
                 coord_t'(-hacm_pkg::ONE), coord_t'(hacm_pkg::ONE)));
    add_directed();
    drain();

    // Extreme corners: the box spans the full coordinate range.
    write_corner(hacm_pkg::REG_ORIGIN, pack3(coord_t'(hacm_pkg::SAT_MIN),
                 coord_t'(hacm_pkg::SAT_MIN), coord_t'(hacm_pkg::SAT_MIN)));
    write_corner(hacm_pkg::REG_ALONG_X, pack3(coord_t'(hacm_pkg::SAT_MAX),
                 coord_t'(hacm_pkg::SAT_MIN), coord_t'(hacm_pkg::SAT_MIN)));
    write_corner(hacm_pkg::REG_ALONG_Y, pack3(coord_t'(hacm_pkg::SAT_MIN),
                 coord_t'(hacm_pkg::SAT_MAX), coord_t'(hacm_pkg::SAT_MIN)));
    write_corner(hacm_pkg::REG_ALONG_Z, pack3(coord_t'(hacm_pkg::SAT_MIN),
                 coord_t'(hacm_pkg::SAT_MIN), coord_t'(hacm_pkg::SAT_MAX)));
    add_directed();
    run_phase(150, 1, 1);

    // All ones in every register.
    for (int i = 0; i < 4; i++) write_corner(i[1:0], '1);
    run_phase(60, 0, 0);

    // Random boxes, with and without idling; the hold-off lands in here.
    for (int ph = 0; ph < 8; ph++) begin
      set_box(($urandom_range(0, 1) == 0) ? 4000 : 0,
              ($urandom_range(0, 1) == 0) ? 5000 : 0);
      if (ph == 1) hold_arm = 1'b1;
      run_phase(150, ph % 2 == 0, ph % 3 != 0);
    end

    // Fully random corners: skewed, usually not degenerate.
    for (int ph = 0; ph < 2; ph++) begin
      for (int i = 0; i < 4; i++)
        write_corner(i[1:0], hacm_pkg::CFG_BITS'({$urandom, $urandom}));
      run_phase(100, 1, 1);
    end

    // Flat box: one edge of zero length.
    set_box(3000, 3000);
    write_corner(hacm_pkg::REG_ALONG_Z, corner[hacm_pkg::REG_ORIGIN]);
    run_phase(50, 1, 0);

    if (errors == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end
endmodule
